/* hdl/pfd_pkg.sv */
`default_nettype none

package pfd_pkg;

    localparam int COEF_W    = 32;
    localparam int STATE_W   = 48;
    localparam int OPND_W    = 52;               // widest multiplicand: e + 2*integ
    localparam int ACC_W     = OPND_W + COEF_W;  // full product before rounding shift
    localparam int REG_COUNT = 6;
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W    = 3;

    localparam logic [CFG_IDX_W-1:0] REG_KP  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_KI  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_DIN = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_DFB = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_DGE = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_DGS = CFG_IDX_W'(5);

    localparam logic signed [COEF_W-1:0] COEF_RESET [REG_COUNT] = '{
        32'sd231106, 32'sd39507, 32'sd4689063, -32'sd1979025, 32'sd210134, 32'sd663166
    };

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(4);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_P,
        ST_INTEG,
        ST_TSUM,
        ST_I,
        ST_DA,
        ST_DB,
        ST_DC,
        ST_DD,
        ST_SUM
    } pfd_state_t;

    typedef enum logic [2:0] {
        MS_NONE,
        MS_LOAD,
        MS_LO,
        MS_HI,
        MS_ACC,
        MS_FIN
    } mstep_t;

    typedef enum logic [2:0] {
        PS_P,
        PS_I,
        PS_DA,
        PS_DB,
        PS_DC,
        PS_DD
    } prod_sel_t;

    typedef struct packed {
        logic      capture;
        logic      integ_upd;
        logic      t_upd;
        logic      out_load;
        mstep_t    step;
        prod_sel_t sel;
    } pfd_cmd_t;

endpackage

`default_nettype wire

/* hdl/pfd_ctrl.sv */
`default_nettype none

module pfd_ctrl
    import pfd_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  wire logic     m_ready,
    output pfd_cmd_t      cmd
);

    pfd_state_t          state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        logic in_prod;
        logic prod_done;
        mstep_t step_code;

        in_prod       = 1'b0;
        prod_done     = (step_reg == STEP_LAST);
        state_next    = state_reg;
        step_next     = step_reg;
        cmd.capture   = 1'b0;
        cmd.integ_upd = 1'b0;
        cmd.t_upd     = 1'b0;
        cmd.out_load  = 1'b0;
        cmd.step      = MS_NONE;
        cmd.sel       = PS_P;

        case (step_reg)
            STEP_W'(0): step_code = MS_LOAD;
            STEP_W'(1): step_code = MS_LO;
            STEP_W'(2): step_code = MS_HI;
            STEP_W'(3): step_code = MS_ACC;
            STEP_LAST:  step_code = MS_FIN;
            default:    step_code = MS_NONE;
        endcase

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_P;
                end
            end
            ST_P: begin
                cmd.sel = PS_P;
                in_prod = 1'b1;
                if (prod_done) state_next = ST_INTEG;
            end
            ST_INTEG: begin
                cmd.integ_upd = 1'b1;
                state_next    = ST_TSUM;
            end
            ST_TSUM: begin
                cmd.t_upd  = 1'b1;
                state_next = ST_I;
            end
            ST_I: begin
                cmd.sel = PS_I;
                in_prod = 1'b1;
                if (prod_done) state_next = ST_DA;
            end
            ST_DA: begin
                cmd.sel = PS_DA;
                in_prod = 1'b1;
                if (prod_done) state_next = ST_DB;
            end
            ST_DB: begin
                cmd.sel = PS_DB;
                in_prod = 1'b1;
                if (prod_done) state_next = ST_DC;
            end
            ST_DC: begin
                cmd.sel = PS_DC;
                in_prod = 1'b1;
                if (prod_done) state_next = ST_DD;
            end
            ST_DD: begin
                cmd.sel = PS_DD;
                in_prod = 1'b1;
                if (prod_done) state_next = ST_SUM;
            end
            ST_SUM: begin
                // hold here until the previous output word has been taken
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (in_prod) begin
            cmd.step  = step_code;
            step_next = prod_done ? '0 : step_reg + STEP_W'(1);
        end

        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

/* hdl/pfd_datapath.sv */
`default_nettype none

module pfd_datapath
    import pfd_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int COEF_FRAC  = 24
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire pfd_cmd_t                     cmd,
    input  wire logic                         cfg_we,
    input  wire logic [CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [COEF_W-1:0]            cfg_wdata,
    input  wire logic signed [DATA_WIDTH-1:0] s_error_sample,
    output logic signed [DATA_WIDTH-1:0]      m_drive,
    output logic signed [DATA_WIDTH-1:0]      m_p_part,
    output logic signed [DATA_WIDTH-1:0]      m_i_part,
    output logic signed [DATA_WIDTH-1:0]      m_d_part,
    output logic                              m_saturated
);

    localparam int SH_W  = 5;
    localparam int RES_W = 65;
    localparam int MAG_W = 63;

    localparam logic [SH_W-1:0] SH_BASE = SH_W'(COEF_FRAC);
    localparam logic [SH_W-1:0] SH_I    = SH_W'(COEF_FRAC + 1);

    localparam logic signed [RES_W-1:0] D_MAX =
        $signed((RES_W'(1) << (DATA_WIDTH - 1)) - RES_W'(1));
    localparam logic signed [RES_W-1:0] D_MIN = ~D_MAX;
    localparam logic signed [RES_W-1:0] S_MAX =
        $signed((RES_W'(1) << (STATE_W - 1)) - RES_W'(1));
    localparam logic signed [RES_W-1:0] S_MIN = ~S_MAX;

    logic signed [COEF_W-1:0]     coef_reg [REG_COUNT];
    logic signed [DATA_WIDTH-1:0] err_reg;
    logic signed [STATE_W-1:0]    integ_reg, integ_next;
    logic signed [STATE_W-1:0]    dstate_reg, dstate_next;
    logic signed [OPND_W-1:0]     t_reg, t_next;
    logic [OPND_W-1:0]            amag_reg, amag_next;
    logic [COEF_W-1:0]            bmag_reg, bmag_next;
    logic                         neg_reg;
    logic [SH_W-1:0]              sh_reg, sh_next;
    logic [2*COEF_W-1:0]          prod_reg;
    logic [ACC_W-1:0]             acc_reg;
    logic signed [RES_W-1:0]      tmp_reg;
    logic signed [DATA_WIDTH-1:0] p_reg, i_reg, d_reg;
    logic                         clip_reg;
    logic signed [DATA_WIDTH-1:0] drive_reg, p_out_reg, i_out_reg, d_out_reg;
    logic                         sat_out_reg;

    logic signed [OPND_W-1:0]     err_ext, integ_ext, dstate_ext, opnd_a;
    logic signed [COEF_W-1:0]     opnd_b;
    logic signed [STATE_W:0]      integ_sum;
    logic                         integ_clip;

    logic [ACC_W-1:0]             mag_full;
    logic                         over;
    logic [MAG_W-1:0]             mag;
    logic signed [RES_W-1:0]      mag_ext, base, res;
    logic                         is_diff;
    logic signed [DATA_WIDTH-1:0] res_dw;
    logic                         res_dw_clip;
    logic                         res_st_clip;

    logic signed [DATA_WIDTH+1:0] sum_ext;
    logic [2:0]                   sum_top;
    logic                         sum_clip;
    logic signed [DATA_WIDTH-1:0] sum_sat;

    assign err_ext    = {{(OPND_W-DATA_WIDTH){err_reg[DATA_WIDTH-1]}}, err_reg};
    assign integ_ext  = {{(OPND_W-STATE_W){integ_reg[STATE_W-1]}}, integ_reg};
    assign dstate_ext = {{(OPND_W-STATE_W){dstate_reg[STATE_W-1]}}, dstate_reg};

    // integrator: grows by one error LSB, i.e. e/2 in its Q31.17 format
    assign integ_sum  = integ_reg + err_reg;
    assign integ_clip = integ_sum[STATE_W] != integ_sum[STATE_W-1];
    always_comb begin
        if (integ_clip) begin
            integ_next = integ_sum[STATE_W] ? S_MIN[STATE_W-1:0] : S_MAX[STATE_W-1:0];
        end else begin
            integ_next = integ_sum[STATE_W-1:0];
        end
    end

    assign t_next = err_ext + {integ_ext[OPND_W-2:0], 1'b0};

    // operand select and sign/magnitude split
    always_comb begin
        opnd_a  = err_ext;
        opnd_b  = coef_reg[REG_KP];
        sh_next = SH_BASE;
        case (cmd.sel)
            PS_P: begin
                opnd_a = err_ext;
                opnd_b = coef_reg[REG_KP];
            end
            PS_I: begin
                opnd_a  = t_reg;
                opnd_b  = coef_reg[REG_KI];
                sh_next = SH_I;
            end
            PS_DA: begin
                opnd_a = err_ext;
                opnd_b = coef_reg[REG_DIN];
            end
            PS_DB: begin
                opnd_a = dstate_ext;
                opnd_b = coef_reg[REG_DFB];
            end
            PS_DC: begin
                opnd_a = err_ext;
                opnd_b = coef_reg[REG_DGE];
            end
            PS_DD: begin
                opnd_a = dstate_ext;
                opnd_b = coef_reg[REG_DGS];
            end
            default: ;
        endcase
        amag_next = opnd_a[OPND_W-1] ? (~$unsigned(opnd_a) + OPND_W'(1)) : $unsigned(opnd_a);
        bmag_next = opnd_b[COEF_W-1] ? (~$unsigned(opnd_b) + COEF_W'(1)) : $unsigned(opnd_b);
    end

    // finish: rounding shift, clamp at 2^62, then one add/sub folds in the sign
    assign mag_full = acc_reg >> sh_reg;
    assign over     = |mag_full[ACC_W-1:MAG_W-1];
    assign mag      = over ? {1'b1, {(MAG_W-1){1'b0}}} : mag_full[MAG_W-1:0];
    assign mag_ext  = $signed({2'b00, mag});
    assign is_diff  = (cmd.sel == PS_DB) || (cmd.sel == PS_DD);
    assign base     = is_diff ? tmp_reg : '0;
    assign res      = (neg_reg ~^ is_diff) ? (base + mag_ext) : (base - mag_ext);

    assign res_dw_clip = (res > D_MAX) || (res < D_MIN);
    always_comb begin
        if (res > D_MAX) begin
            res_dw = D_MAX[DATA_WIDTH-1:0];
        end else if (res < D_MIN) begin
            res_dw = D_MIN[DATA_WIDTH-1:0];
        end else begin
            res_dw = res[DATA_WIDTH-1:0];
        end
    end

    assign res_st_clip = (res > S_MAX) || (res < S_MIN);
    always_comb begin
        if (res > S_MAX) begin
            dstate_next = S_MAX[STATE_W-1:0];
        end else if (res < S_MIN) begin
            dstate_next = S_MIN[STATE_W-1:0];
        end else begin
            dstate_next = res[STATE_W-1:0];
        end
    end

    assign sum_ext  = p_reg + i_reg + d_reg;
    assign sum_top  = sum_ext[DATA_WIDTH+1:DATA_WIDTH-1];
    assign sum_clip = !((&sum_top) || (~|sum_top));
    always_comb begin
        if (sum_clip) begin
            sum_sat = sum_ext[DATA_WIDTH+1] ? D_MIN[DATA_WIDTH-1:0] : D_MAX[DATA_WIDTH-1:0];
        end else begin
            sum_sat = sum_ext[DATA_WIDTH-1:0];
        end
    end

    // coefficients and filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < REG_COUNT; k++) begin
                coef_reg[k] <= COEF_RESET[k];
            end
            integ_reg  <= '0;
            dstate_reg <= '0;
        end else begin
            if (cfg_we && (cfg_index < CFG_IDX_W'(REG_COUNT))) begin
                coef_reg[cfg_index] <= cfg_wdata;
            end
            if (cmd.integ_upd) begin
                integ_reg <= integ_next;
            end
            if ((cmd.step == MS_FIN) && (cmd.sel == PS_DB)) begin
                dstate_reg <= dstate_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            err_reg  <= s_error_sample;
            clip_reg <= 1'b0;
        end
        if (cmd.integ_upd && integ_clip) begin
            clip_reg <= 1'b1;
        end
        if (cmd.t_upd) begin
            t_reg <= t_next;
        end
        case (cmd.step)
            MS_LOAD: begin
                amag_reg <= amag_next;
                bmag_reg <= bmag_next;
                neg_reg  <= opnd_a[OPND_W-1] ^ opnd_b[COEF_W-1];
                sh_reg   <= sh_next;
            end
            MS_LO: begin
                prod_reg <= amag_reg[COEF_W-1:0] * bmag_reg;
            end
            MS_HI: begin
                acc_reg  <= ACC_W'(prod_reg) + (ACC_W'(1) << (sh_reg - SH_W'(1)));
                prod_reg <= COEF_W'(amag_reg[OPND_W-1:COEF_W]) * bmag_reg;
            end
            MS_ACC: begin
                acc_reg <= acc_reg + {prod_reg[OPND_W-1:0], {COEF_W{1'b0}}};
            end
            MS_FIN: begin
                case (cmd.sel)
                    PS_P: begin
                        p_reg    <= res_dw;
                        clip_reg <= clip_reg | over | res_dw_clip;
                    end
                    PS_I: begin
                        i_reg    <= res_dw;
                        clip_reg <= clip_reg | over | res_dw_clip;
                    end
                    PS_DA, PS_DC: begin
                        tmp_reg  <= res;
                        clip_reg <= clip_reg | over;
                    end
                    PS_DB: begin
                        clip_reg <= clip_reg | over | res_st_clip;
                    end
                    PS_DD: begin
                        d_reg    <= res_dw;
                        clip_reg <= clip_reg | over | res_dw_clip;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        if (cmd.out_load) begin
            drive_reg   <= sum_sat;
            p_out_reg   <= p_reg;
            i_out_reg   <= i_reg;
            d_out_reg   <= d_reg;
            sat_out_reg <= clip_reg | sum_clip;
        end
    end

    assign m_drive     = drive_reg;
    assign m_p_part    = p_out_reg;
    assign m_i_part    = i_out_reg;
    assign m_d_part    = d_out_reg;
    assign m_saturated = sat_out_reg;

endmodule

`default_nettype wire

/* hdl/pid_filtered_derivative_unit.sv */
// PID controller with first-order filtered derivative, fixed point. Each error word
// (signed Q16.16) yields one result word: drive = P + I + D and the three parts, each
// saturated to DATA_WIDTH bits, plus a flag set when any product, state or sum clipped.
// Gains are six signed Q8.24 registers written through the cfg port (index 0..5: kp,
// ki*Ts, derivative input scale, derivative feedback scale, derivative error gain,
// derivative state gain; other indexes are ignored); write them only while the block is
// idle. All six products run on one shared 32x32 multiplier, two partial products each,
// each stepped through load, low, high, accumulate and finish. An item passes the P
// product, the integrator and operand updates, the I and four derivative products and
// the final sum before the unit takes the next, provided the previous result has been
// taken. The integrator and derivative states are cleared by reset.
`default_nettype none

module pid_filtered_derivative_unit
    import pfd_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int COEF_FRAC  = 24
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic signed [DATA_WIDTH-1:0] s_error_sample,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [DATA_WIDTH-1:0]      m_drive,
    output logic signed [DATA_WIDTH-1:0]      m_p_part,
    output logic signed [DATA_WIDTH-1:0]      m_i_part,
    output logic signed [DATA_WIDTH-1:0]      m_d_part,
    output logic                              m_saturated,
    input  wire logic                         cfg_we,
    input  wire logic [CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [COEF_W-1:0]            cfg_wdata
);

    pfd_cmd_t cmd;

    pfd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    pfd_datapath #(
        .DATA_WIDTH (DATA_WIDTH),
        .COEF_FRAC  (COEF_FRAC)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_error_sample (s_error_sample),
        .m_drive        (m_drive),
        .m_p_part       (m_p_part),
        .m_i_part       (m_i_part),
        .m_d_part       (m_d_part),
        .m_saturated    (m_saturated)
    );

endmodule

`default_nettype wire

/* hdl/pfd_checker.sv */
`default_nettype none

module pfd_checker #(
    parameter int DATA_WIDTH = 32
) (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_valid,
    input wire logic                         s_ready,
    input wire logic                         m_valid,
    input wire logic                         m_ready,
    input wire logic signed [DATA_WIDTH-1:0] m_drive,
    input wire logic signed [DATA_WIDTH-1:0] m_p_part,
    input wire logic signed [DATA_WIDTH-1:0] m_i_part,
    input wire logic signed [DATA_WIDTH-1:0] m_d_part,
    input wire logic                         m_saturated
);

    logic signed [DATA_WIDTH+1:0] part_sum;
    logic signed [DATA_WIDTH+1:0] drive_ext;

    assign part_sum  = m_p_part + m_i_part + m_d_part;
    assign drive_ext = m_drive;

    // a stalled result word stays offered
    a_out_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped while stalled");

    a_out_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_drive) && $stable(m_p_part)
                                && $stable(m_i_part) && $stable(m_d_part)
                                && $stable(m_saturated))
        else $error("result word changed while stalled");

    // one word in flight: no new input right after one is taken
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");

    // without the clip flag the drive is the exact sum of its parts
    a_sum_exact: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_saturated |-> part_sum == drive_ext)
        else $error("drive differs from P+I+D without saturation");

endmodule

bind pid_filtered_derivative_unit pfd_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_pfd_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_drive     (m_drive),
    .m_p_part    (m_p_part),
    .m_i_part    (m_i_part),
    .m_d_part    (m_d_part),
    .m_saturated (m_saturated)
);

`default_nettype wire
